/* sv/tdwp_pkg.sv */
// Shared types, constants and the arctangent table of the waypoint controller.
`default_nettype none
package tdwp_pkg;

  localparam int NUM_REGS         = 7;
  localparam int MAX_RESULTS      = 5;
  localparam int ZERO_REPEATS_DEF = 5;
  localparam int CORDIC_STEPS     = 16;
  localparam int SQRT_STEPS       = 18;

  localparam logic [2:0] REG_TURN_KP  = 3'd0;
  localparam logic [2:0] REG_TURN_KI  = 3'd1;
  localparam logic [2:0] REG_TURN_KD  = 3'd2;
  localparam logic [2:0] REG_DRIVE_KP = 3'd3;
  localparam logic [2:0] REG_DRIVE_KI = 3'd4;
  localparam logic [2:0] REG_DRIVE_KD = 3'd5;
  localparam logic [2:0] REG_STEP     = 3'd6;

  localparam logic [15:0] RST_TURN_KP  = 16'd2048;
  localparam logic [15:0] RST_TURN_KI  = 16'd164;
  localparam logic [15:0] RST_TURN_KD  = 16'd819;
  localparam logic [15:0] RST_DRIVE_KP = 16'd2048;
  localparam logic [15:0] RST_DRIVE_KI = 16'd41;
  localparam logic [15:0] RST_DRIVE_KD = 16'd901;
  localparam logic [15:0] RST_STEP     = 16'd20;

  localparam logic [1:0] PH_ORIENT  = 2'd0;
  localparam logic [1:0] PH_DRIVE   = 2'd1;
  localparam logic [1:0] PH_REACHED = 2'd2;

  localparam logic signed [18:0] TOL_ALPHA     = 19'sd41;
  localparam logic signed [18:0] TOL_RHO       = 19'sd82;
  localparam logic signed [15:0] PRELOAD_DRIVE = 16'sd3686;
  localparam logic signed [15:0] PRELOAD_TURN  = 16'sd12288;
  localparam logic signed [19:0] HALF_PI_Q16   = 20'sd102944;

  typedef struct packed {
    logic [15:0] turn_kp;
    logic [15:0] turn_ki;
    logic [15:0] turn_kd;
    logic [15:0] drive_kp;
    logic [15:0] drive_ki;
    logic [15:0] drive_kd;
    logic [15:0] step;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORDIC, ST_SQ_X, ST_SQ_Y, ST_SUM, ST_SQRT, ST_ERR,
    ST_MUL_I, ST_INTEG, ST_ACC_P, ST_ACC_D, ST_ACC_I, ST_FINISH, ST_OUT
  } state_t;

  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] v;
    unique case (i)
      4'd0:  v = 16'd51472;
      4'd1:  v = 16'd30386;
      4'd2:  v = 16'd16055;
      4'd3:  v = 16'd8150;
      4'd4:  v = 16'd4091;
      4'd5:  v = 16'd2047;
      4'd6:  v = 16'd1024;
      4'd7:  v = 16'd512;
      4'd8:  v = 16'd256;
      4'd9:  v = 16'd128;
      4'd10: v = 16'd64;
      4'd11: v = 16'd32;
      4'd12: v = 16'd16;
      4'd13: v = 16'd8;
      4'd14: v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/tdwp_cfg.sv */
// Gain and time step register bank behind the APB-style port.
`default_nettype none
module tdwp_cfg
  import tdwp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [15:0] regs [NUM_REGS];
  logic [2:0]  idx;
  logic        idx_ok;

  assign idx    = paddr[4:2];
  assign idx_ok = (32'(idx) < NUM_REGS);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_TURN_KP]  <= RST_TURN_KP;
      regs[REG_TURN_KI]  <= RST_TURN_KI;
      regs[REG_TURN_KD]  <= RST_TURN_KD;
      regs[REG_DRIVE_KP] <= RST_DRIVE_KP;
      regs[REG_DRIVE_KI] <= RST_DRIVE_KI;
      regs[REG_DRIVE_KD] <= RST_DRIVE_KD;
      regs[REG_STEP]     <= RST_STEP;
    end else if (psel && penable && pwrite && idx_ok) begin
      regs[idx] <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (idx_ok) begin
      prdata = {16'd0, regs[idx]};
    end
  end

  assign cfg.turn_kp  = regs[REG_TURN_KP];
  assign cfg.turn_ki  = regs[REG_TURN_KI];
  assign cfg.turn_kd  = regs[REG_TURN_KD];
  assign cfg.drive_kp = regs[REG_DRIVE_KP];
  assign cfg.drive_ki = regs[REG_DRIVE_KI];
  assign cfg.drive_kd = regs[REG_DRIVE_KD];
  assign cfg.step     = regs[REG_STEP];

endmodule
`default_nettype wire

/* sv/turn_then_drive_waypoint_pid_unit.sv */
// Turn-then-drive waypoint controller: sequencer around one shared multiplier.
// Input channel (in_valid/in_stall) carries one control tick: pose and goal.
// Output channel (out_valid/out_stall) returns one to MAX_RESULTS commands per
// tick; last marks the final one. Gains and the time step sit behind the APB
// port; the user writes them only while the block is idle, which the block
// does not enforce. One tick is worked at a time; in_stall stays high from
// acceptance until the last result transfer. Orient ticks run a 16-step
// CORDIC, drive ticks two squares, a sum and an 18-step square root, both
// followed by an error step and the PID steps on the shared multiplier; an
// error within tolerance skips the PID steps. Stopped, missing-goal and
// reached ticks raise out_valid in the cycle after acceptance. The next tick
// can be accepted in the cycle after the last result transfer.
// Reset (synchronous, active high) restores the register defaults, enters the
// orient phase, clears both integrators and the held commands and preloads
// the last command with 3.0. A stalled result holds until out_stall drops.
`default_nettype none
module turn_then_drive_waypoint_pid_unit
  import tdwp_pkg::*;
#(
  parameter int ZERO_REPEATS = ZERO_REPEATS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [14:0] heading,
  input  wire logic signed [15:0] goal_x,
  input  wire logic signed [15:0] goal_y,
  input  wire logic               goal_valid,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      linear_cmd,
  output logic signed [15:0]      angular_cmd,
  output logic                    publish,
  output logic                    advance_goal,
  output logic                    done_res,
  output logic                    last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int NZero = (ZERO_REPEATS < MAX_RESULTS) ? ZERO_REPEATS : MAX_RESULTS;
  localparam int CntW  = $clog2(MAX_RESULTS + 1);

  cfg_t cfg;

  tdwp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state, state_next;

  logic [1:0]         phase;
  logic               stopped;
  logic signed [15:0] last_command;
  logic signed [31:0] turn_integral;
  logic signed [31:0] drive_integral;
  logic signed [15:0] held_linear;
  logic signed [15:0] held_angular;

  logic signed [16:0] dx, dy;
  logic signed [14:0] head;
  logic signed [31:0] cx, cy;
  logic signed [19:0] cz;
  logic               zflag;
  logic [4:0]         iter;
  logic [35:0]        sq;
  logic [36:0]        sr;
  logic [35:0]        sbit;
  logic signed [18:0] err;
  logic signed [51:0] prod, acc;
  logic signed [32:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [51:0] mul_out;

  logic signed [15:0] res_lin, res_ang;
  logic               res_pub, res_adv, res_done;
  logic [CntW-1:0]    cnt;

  logic               in_fire, out_fire;
  logic signed [16:0] dx_in, dy_in;
  logic signed [31:0] x0, y0;
  logic signed [31:0] xs, ys;
  logic signed [19:0] atan_s;
  logic signed [19:0] zsel;
  logic signed [20:0] adiff;
  logic signed [16:0] ashift;
  logic signed [18:0] angle_err;
  logic signed [18:0] err_now;
  logic               tol_hit;
  logic [36:0]        trial;
  logic signed [31:0] integ_sel;
  logic [15:0]        kp_sel, ki_sel, kd_sel;
  logic signed [39:0] inc;
  logic signed [40:0] integ_sum;
  logic signed [31:0] integ_new;
  logic signed [39:0] cmd_r;
  logic signed [15:0] cmd;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  assign dx_in = {goal_x[15], goal_x} - {pos_x[15], pos_x};
  assign dy_in = {goal_y[15], goal_y} - {pos_y[15], pos_y};
  assign x0    = {{3{dx_in[16]}}, dx_in, 12'd0};
  assign y0    = {{3{dy_in[16]}}, dy_in, 12'd0};

  assign xs     = cx >>> iter[3:0];
  assign ys     = cy >>> iter[3:0];
  assign atan_s = signed'({4'd0, atan_q16(iter[3:0])});

  assign zsel   = zflag ? 20'sd0 : cz;
  assign adiff  = 21'(zsel) - (21'(head) <<< 4) + 21'sd8;
  assign ashift = 17'(adiff >>> 4);
  always_comb begin
    if (ashift > 17'sd32767) begin
      angle_err = 19'sd32767;
    end else if (ashift < -17'sd32768) begin
      angle_err = -19'sd32768;
    end else begin
      angle_err = 19'(ashift);
    end
  end

  assign err_now = (phase == PH_ORIENT) ? angle_err : signed'(sr[18:0]);
  assign tol_hit = (phase == PH_ORIENT) ? (err_now >= -TOL_ALPHA && err_now <= TOL_ALPHA)
                                        : (err_now <= TOL_RHO);

  assign trial = sr + {1'b0, sbit};

  assign integ_sel = (phase == PH_ORIENT) ? turn_integral : drive_integral;
  assign kp_sel    = (phase == PH_ORIENT) ? cfg.turn_kp : cfg.drive_kp;
  assign ki_sel    = (phase == PH_ORIENT) ? cfg.turn_ki : cfg.drive_ki;
  assign kd_sel    = (phase == PH_ORIENT) ? cfg.turn_kd : cfg.drive_kd;

  assign inc       = 40'((prod + 52'sd2048) >>> 12);
  assign integ_sum = 41'(integ_sel) + 41'(inc);
  always_comb begin
    if (integ_sum > 41'sd2147483647) begin
      integ_new = 32'sh7fffffff;
    end else if (integ_sum < -41'sd2147483648) begin
      integ_new = 32'sh80000000;
    end else begin
      integ_new = 32'(integ_sum);
    end
  end

  assign cmd_r = 40'((acc + 52'sd2048) >>> 12);
  always_comb begin
    if (cmd_r > 40'sd32767) begin
      cmd = 16'sd32767;
    end else if (cmd_r < -40'sd32768) begin
      cmd = -16'sd32768;
    end else begin
      cmd = 16'(cmd_r);
    end
  end

  always_comb begin
    unique case (state)
      ST_SQ_X: begin
        mul_a = 33'(dx);
        mul_b = 19'(dx);
      end
      ST_SQ_Y: begin
        mul_a = 33'(dy);
        mul_b = 19'(dy);
      end
      ST_MUL_I: begin
        mul_a = 33'(err);
        mul_b = signed'({3'd0, cfg.step});
      end
      ST_INTEG: begin
        mul_a = 33'(err);
        mul_b = signed'({3'd0, kp_sel});
      end
      ST_ACC_P: begin
        mul_a = 33'(last_command);
        mul_b = signed'({3'd0, kd_sel});
      end
      ST_ACC_D: begin
        mul_a = 33'(integ_sel);
        mul_b = signed'({3'd0, ki_sel});
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 19'sd0;
      end
    endcase
  end
  assign mul_out = 52'(mul_a) * 52'(mul_b);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (stopped || !goal_valid) begin
            state_next = ST_OUT;
          end else if (phase == PH_ORIENT) begin
            state_next = ST_CORDIC;
          end else if (phase == PH_DRIVE) begin
            state_next = ST_SQ_X;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_CORDIC: begin
        if (iter == 5'(CORDIC_STEPS - 1)) begin
          state_next = ST_ERR;
        end
      end
      ST_SQ_X:   state_next = ST_SQ_Y;
      ST_SQ_Y:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_SQRT;
      ST_SQRT: begin
        if (iter == 5'(SQRT_STEPS - 1)) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR:    state_next = tol_hit ? ST_OUT : ST_MUL_I;
      ST_MUL_I:  state_next = ST_INTEG;
      ST_INTEG:  state_next = ST_ACC_P;
      ST_ACC_P:  state_next = ST_ACC_D;
      ST_ACC_D:  state_next = ST_ACC_I;
      ST_ACC_I:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: begin
        if (out_fire && cnt == CntW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != ST_IDLE);
    out_valid    = (state == ST_OUT);
    linear_cmd   = res_lin;
    angular_cmd  = res_ang;
    publish      = res_pub;
    advance_goal = res_adv;
    done_res     = res_done;
    last         = (cnt == CntW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ORIENT;
      stopped        <= 1'b0;
      last_command   <= PRELOAD_TURN;
      turn_integral  <= 32'sd0;
      drive_integral <= 32'sd0;
      held_linear    <= 16'sd0;
      held_angular   <= 16'sd0;
      cnt            <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            dx   <= dx_in;
            dy   <= dy_in;
            head <= heading;
            iter <= 5'd0;
            cnt  <= CntW'(1);
            res_adv  <= 1'b0;
            res_done <= 1'b0;
            zflag    <= (dx_in == 17'sd0) && (dy_in == 17'sd0);
            if (!dx_in[16]) begin
              cx <= x0;
              cy <= y0;
              cz <= 20'sd0;
            end else if (!dy_in[16]) begin
              cx <= y0;
              cy <= -x0;
              cz <= HALF_PI_Q16;
            end else begin
              cx <= -y0;
              cy <= x0;
              cz <= -HALF_PI_Q16;
            end
            if (stopped) begin
              res_lin  <= 16'sd0;
              res_ang  <= 16'sd0;
              res_pub  <= 1'b0;
              res_done <= 1'b1;
            end else if (!goal_valid) begin
              held_linear  <= 16'sd0;
              held_angular <= 16'sd0;
              stopped      <= 1'b1;
              res_lin      <= 16'sd0;
              res_ang      <= 16'sd0;
              res_pub      <= 1'b1;
              res_done     <= 1'b1;
            end else if (phase != PH_ORIENT && phase != PH_DRIVE) begin
              phase   <= PH_ORIENT;
              res_lin <= held_linear;
              res_ang <= held_angular;
              res_pub <= 1'b0;
              res_adv <= 1'b1;
            end
          end
        end
        ST_CORDIC: begin
          iter <= iter + 5'd1;
          if (!cy[31]) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_s;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_s;
          end
          if (iter == 5'(CORDIC_STEPS - 1)) begin
            iter <= 5'd0;
          end
        end
        ST_SQ_X: begin
          prod <= mul_out;
        end
        ST_SQ_Y: begin
          sq   <= prod[35:0];
          prod <= mul_out;
        end
        ST_SUM: begin
          sq   <= sq + prod[35:0];
          sr   <= 37'd0;
          sbit <= 36'd1 << 34;
          iter <= 5'd0;
        end
        ST_SQRT: begin
          iter <= iter + 5'd1;
          sbit <= sbit >> 2;
          if ({1'b0, sq} >= trial) begin
            sq <= 36'({1'b0, sq} - trial);
            sr <= (sr >> 1) + {1'b0, sbit};
          end else begin
            sr <= sr >> 1;
          end
        end
        ST_ERR: begin
          err <= err_now;
          if (tol_hit) begin
            cnt     <= CntW'(NZero);
            res_pub <= 1'b1;
            if (phase == PH_ORIENT) begin
              phase         <= PH_DRIVE;
              turn_integral <= 32'sd0;
              held_angular  <= 16'sd0;
              last_command  <= PRELOAD_DRIVE;
              res_lin       <= held_linear;
              res_ang       <= 16'sd0;
            end else begin
              phase          <= PH_REACHED;
              drive_integral <= 32'sd0;
              held_linear    <= 16'sd0;
              last_command   <= PRELOAD_TURN;
              res_lin        <= 16'sd0;
              res_ang        <= held_angular;
            end
          end
        end
        ST_MUL_I: begin
          prod <= mul_out;
        end
        ST_INTEG: begin
          if (phase == PH_ORIENT) begin
            turn_integral <= integ_new;
          end else begin
            drive_integral <= integ_new;
          end
          prod <= mul_out;
        end
        ST_ACC_P: begin
          acc  <= prod;
          prod <= mul_out;
        end
        ST_ACC_D: begin
          acc  <= acc - prod;
          prod <= mul_out;
        end
        ST_ACC_I: begin
          acc <= acc + prod;
        end
        ST_FINISH: begin
          last_command <= cmd;
          res_pub      <= 1'b1;
          if (phase == PH_ORIENT) begin
            held_angular <= cmd;
            res_lin      <= held_linear;
            res_ang      <= cmd;
          end else begin
            held_linear <= cmd;
            res_lin     <= cmd;
            res_ang     <= held_angular;
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            cnt <= cnt - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire
